>>> hw/rtl/isotp_receive_reassembler_core_macros.svh
// Assertion helpers for the block that checks itself.
`ifndef ISOTP_RECEIVE_REASSEMBLER_CORE_MACROS_SVH
`define ISOTP_RECEIVE_REASSEMBLER_CORE_MACROS_SVH

// Same-cycle implication, idle during reset.
`define ISOTP_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isotp assertion failed");

// Next-cycle implication, idle during reset.
`define ISOTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isotp assertion failed");

`endif

>>> hw/rtl/isotp_pkg.sv
package isotp_pkg;

    // command queue between the frame classifier and the result sequencer
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_SEGMENT = 2'd0,
        KIND_FLOW    = 2'd1,
        KIND_ABORT   = 2'd2
    } t_kind;

    localparam logic [3:0] PCI_SINGLE = 4'h0;
    localparam logic [3:0] PCI_FIRST  = 4'h1;
    localparam logic [3:0] PCI_CONSEC = 4'h2;

    localparam logic [3:0] MAX_FRAME_LEN = 4'd8;
    localparam logic [3:0] SF_MAX_BYTES  = 4'd7;
    localparam logic [3:0] FF_MAX_BYTES  = 4'd6;

    // flow control: continue to send, block size 0, separation time 0
    localparam logic [7:0] FC_CTS      = 8'h30;
    localparam logic [7:0] FC_BS       = 8'h00;
    localparam logic [7:0] FC_ST       = 8'h00;
    localparam logic [2:0] FC_COUNT    = 3'd3;

    typedef struct packed {
        logic            abort;
        logic [11:0]     abort_len;
        logic            seg;
        logic [6:0][7:0] seg_bytes;
        logic [2:0]      seg_count;
        logic [11:0]     seg_len;
        logic            seg_end;
        logic            flow;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        t_kind           kind;
        logic [6:0][7:0] bytes;
        logic [2:0]      count;
        logic [11:0]     msg_len;
        logic            msg_end;
        logic            last;
    } t_result;

endpackage

>>> hw/rtl/isotp_frame_if.sv
interface isotp_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte0;
    logic [7:0] frame_byte1;
    logic [7:0] frame_byte2;
    logic [7:0] frame_byte3;
    logic [7:0] frame_byte4;
    logic [7:0] frame_byte5;
    logic [7:0] frame_byte6;
    logic [7:0] frame_byte7;
    logic [3:0] frame_length;

    modport source (
        output valid, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
               frame_byte4, frame_byte5, frame_byte6, frame_byte7, frame_length,
        input  ready
    );
    modport sink (
        input  valid, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
               frame_byte4, frame_byte5, frame_byte6, frame_byte7, frame_length,
        output ready
    );
endinterface

>>> hw/rtl/isotp_result_if.sv
interface isotp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  out_byte0;
    logic [7:0]  out_byte1;
    logic [7:0]  out_byte2;
    logic [7:0]  out_byte3;
    logic [7:0]  out_byte4;
    logic [7:0]  out_byte5;
    logic [7:0]  out_byte6;
    logic [2:0]  byte_count;
    logic [11:0] message_length;
    logic        message_end;
    logic        last;

    modport source (
        output valid, result_kind, out_byte0, out_byte1, out_byte2, out_byte3,
               out_byte4, out_byte5, out_byte6, byte_count, message_length,
               message_end, last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, out_byte0, out_byte1, out_byte2, out_byte3,
               out_byte4, out_byte5, out_byte6, byte_count, message_length,
               message_end, last,
        output ready
    );
endinterface

>>> hw/rtl/isotp_receive_reassembler_core.sv
// An accepted frame beat reaches the result port through the command queue and the result register.
// Frame beats enter a 4-entry command queue one per cycle while it is not full; results
//   leave one per cycle while the result port is ready; a frame yields k results (k = 0..3).
// The result sequencer sets the sustained rate; the queue absorbs bursts of frames.
// Reset: synchronous, active low; clears reception state (idle, sequence 1), queue and
//   the result valid flag. No clearing pass is needed.
`include "isotp_receive_reassembler_core_macros.svh"

module isotp_receive_reassembler_core
    import isotp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    isotp_frame_if.sink     i_frame,
    isotp_result_if.source  o_result
);

    // Front: classify each frame beat by its PCI nibble, update the reception
    // state and turn the frame into one command (abort / segment / flow flags).
    t_cmd           f_cmd;
    logic           f_push;

    // Queue: decouple frame intake from result delivery.
    t_cmd           q_head;
    t_qstat         q_stat;
    logic [QCW-1:0] q_count;

    // Back: expand the head command into its result beats, one per cycle while the port is ready.
    logic           q_pop;

    // a flow-control beat is on the result port
    logic           res_is_flow;

    isotp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (i_frame),
        .i_qstat (q_stat),
        .o_push  (f_push),
        .o_cmd   (f_cmd)
    );

    isotp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_qstat (q_stat),
        .o_count (q_count)
    );

    isotp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .i_qstat  (q_stat),
        .o_pop    (q_pop),
        .o_result (o_result)
    );

    assign res_is_flow = o_result.valid && (o_result.result_kind == KIND_FLOW);

    // queue occupancy never exceeds its depth
    `ISOTP_ASSERT(a_q_bound, i_clk, i_rst_n, 1'b1, q_count <= QCW'(QDEPTH))
    // a full queue must stall the frame channel
    `ISOTP_ASSERT(a_full_stall, i_clk, i_rst_n, q_stat.full, !i_frame.ready)
    // flow control is always the final result of its frame
    `ISOTP_ASSERT(a_flow_last, i_clk, i_rst_n, res_is_flow, o_result.last)
    // retiring a command loads its last result into the result register
    `ISOTP_ASSERT_NEXT(a_pop_last, i_clk, i_rst_n, q_pop, o_result.valid && o_result.last)

endmodule

>>> hw/rtl/isotp_front.sv
module isotp_front
    import isotp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    isotp_frame_if.sink         i_frame,
    input  t_qstat              i_qstat,
    output logic                o_push,
    output t_cmd                o_cmd
);

    logic        r_active;
    logic [11:0] r_exp;
    logic [11:0] r_rcv;
    logic [3:0]  r_seq;

    logic        n_active;
    logic [11:0] n_exp;
    logic [11:0] n_rcv;
    logic [3:0]  n_seq;

    logic [7:0]  b [8];
    logic [3:0]  len4;
    logic [3:0]  pci;
    logic [3:0]  lo;
    logic [11:0] plen;
    logic [3:0]  n_ff;
    logic [3:0]  n_cf;
    logic [11:0] rem;
    logic [11:0] sum;
    logic        accept;
    t_cmd        cmd;

    assign b[0] = i_frame.frame_byte0;
    assign b[1] = i_frame.frame_byte1;
    assign b[2] = i_frame.frame_byte2;
    assign b[3] = i_frame.frame_byte3;
    assign b[4] = i_frame.frame_byte4;
    assign b[5] = i_frame.frame_byte5;
    assign b[6] = i_frame.frame_byte6;
    assign b[7] = i_frame.frame_byte7;

    assign len4 = (i_frame.frame_length > MAX_FRAME_LEN) ? MAX_FRAME_LEN
                                                         : i_frame.frame_length;
    assign pci  = b[0][7:4];
    assign lo   = b[0][3:0];
    assign plen = {lo, b[1]};
    assign rem  = (r_exp >= r_rcv) ? (r_exp - r_rcv) : 12'd0;

    always_comb begin
        cmd           = '0;
        cmd.abort_len = r_exp;
        n_active      = r_active;
        n_exp         = r_exp;
        n_rcv         = r_rcv;
        n_seq         = r_seq;
        n_ff          = 4'd0;
        n_cf          = 4'd0;
        sum           = r_rcv;
        if (len4 != 4'd0) begin
            case (pci)
                PCI_SINGLE: begin
                    if (lo <= SF_MAX_BYTES && ({1'b0, lo} + 5'd1) <= {1'b0, len4}) begin
                        cmd.abort    = r_active;
                        n_active     = 1'b0;
                        cmd.seg      = 1'b1;
                        cmd.seg_count = lo[2:0];
                        for (int i = 0; i < 7; i++) begin
                            cmd.seg_bytes[i] = (3'(i) < lo[2:0]) ? b[i+1] : 8'd0;
                        end
                        cmd.seg_len  = {8'd0, lo};
                        cmd.seg_end  = 1'b1;
                    end
                end
                PCI_FIRST: begin
                    if (len4 >= 4'd2) begin
                        cmd.abort = r_active;
                        n_active  = 1'b0;
                        if (plen != 12'd0) begin
                            n_ff = len4 - 4'd2;
                            if ({8'd0, n_ff} > plen) begin
                                n_ff = plen[3:0];
                            end
                            if (n_ff > FF_MAX_BYTES) begin
                                n_ff = FF_MAX_BYTES;
                            end
                            n_exp         = plen;
                            n_rcv         = {8'd0, n_ff};
                            n_seq         = 4'd1;
                            n_active      = ({8'd0, n_ff} < plen);
                            cmd.seg       = 1'b1;
                            cmd.seg_count = n_ff[2:0];
                            for (int i = 0; i < 6; i++) begin
                                cmd.seg_bytes[i] = (3'(i) < n_ff[2:0]) ? b[i+2] : 8'd0;
                            end
                            cmd.seg_len   = plen;
                            cmd.seg_end   = !({8'd0, n_ff} < plen);
                            cmd.flow      = 1'b1;
                        end
                    end
                end
                PCI_CONSEC: begin
                    if (len4 >= 4'd2) begin
                        if (!r_active || lo != r_seq) begin
                            // out of order or unsolicited: drop the reception
                            cmd.abort = r_active;
                            n_active  = 1'b0;
                        end else begin
                            n_cf = len4 - 4'd1;
                            if ({8'd0, n_cf} > rem) begin
                                n_cf = rem[3:0];
                            end
                            sum           = r_rcv + {8'd0, n_cf};
                            n_rcv         = sum;
                            n_seq         = r_seq + 4'd1;
                            n_active      = !(sum >= r_exp);
                            cmd.seg       = 1'b1;
                            cmd.seg_count = n_cf[2:0];
                            for (int i = 0; i < 7; i++) begin
                                cmd.seg_bytes[i] = (3'(i) < n_cf[2:0]) ? b[i+1] : 8'd0;
                            end
                            cmd.seg_len   = r_exp;
                            cmd.seg_end   = (sum >= r_exp);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign i_frame.ready = !i_qstat.full;
    assign accept        = i_frame.valid && !i_qstat.full;
    assign o_push        = accept && (cmd.abort || cmd.seg || cmd.flow);
    assign o_cmd         = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_exp    <= 12'd0;
            r_rcv    <= 12'd0;
            r_seq    <= 4'd1;
        end else if (accept) begin
            r_active <= n_active;
            r_exp    <= n_exp;
            r_rcv    <= n_rcv;
            r_seq    <= n_seq;
        end
    end

endmodule

>>> hw/rtl/isotp_queue.sv
module isotp_queue
    import isotp_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  t_cmd           i_cmd,
    input  logic           i_pop,
    output t_cmd           o_head,
    output t_qstat         o_qstat,
    output logic [QCW-1:0] o_count
);

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QCW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_qstat.full  = (r_count == QCW'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_count       = r_count;
    assign o_head        = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hw/rtl/isotp_back.sv
module isotp_back
    import isotp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_head,
    input  t_qstat          i_qstat,
    output logic            o_pop,
    isotp_result_if.source  o_result
);

    // done flags of the head command: [0] abort, [1] segment, [2] flow
    logic [2:0] r_done;
    logic       r_valid;
    t_result    r_res;

    logic       pend_a;
    logic       pend_s;
    logic       pend_f;
    logic       advance;
    logic       more;
    logic [2:0] sel_mask;
    t_result    n_res;

    assign pend_a  = i_head.abort && !r_done[0];
    assign pend_s  = i_head.seg   && !r_done[1];
    assign pend_f  = i_head.flow  && !r_done[2];
    assign advance = !i_qstat.empty && (!r_valid || o_result.ready);

    always_comb begin
        n_res = '0;
        if (pend_a) begin
            n_res.kind    = KIND_ABORT;
            n_res.msg_len = i_head.abort_len;
            sel_mask      = 3'b001;
            more          = pend_s || pend_f;
        end else if (pend_s) begin
            n_res.kind    = KIND_SEGMENT;
            n_res.bytes   = i_head.seg_bytes;
            n_res.count   = i_head.seg_count;
            n_res.msg_len = i_head.seg_len;
            n_res.msg_end = i_head.seg_end;
            sel_mask      = 3'b010;
            more          = pend_f;
        end else begin
            n_res.kind     = KIND_FLOW;
            n_res.bytes[0] = FC_CTS;
            n_res.bytes[1] = FC_BS;
            n_res.bytes[2] = FC_ST;
            n_res.count    = FC_COUNT;
            n_res.msg_len  = i_head.seg_len;
            sel_mask       = 3'b100;
            more           = 1'b0;
        end
        n_res.last = !more;
    end

    assign o_pop = advance && !more;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= 3'b000;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                r_done  <= more ? (r_done | sel_mask) : 3'b000;
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid          = r_valid;
    assign o_result.result_kind    = r_res.kind;
    assign o_result.out_byte0      = r_res.bytes[0];
    assign o_result.out_byte1      = r_res.bytes[1];
    assign o_result.out_byte2      = r_res.bytes[2];
    assign o_result.out_byte3      = r_res.bytes[3];
    assign o_result.out_byte4      = r_res.bytes[4];
    assign o_result.out_byte5      = r_res.bytes[5];
    assign o_result.out_byte6      = r_res.bytes[6];
    assign o_result.byte_count     = r_res.count;
    assign o_result.message_length = r_res.msg_len;
    assign o_result.message_end    = r_res.msg_end;
    assign o_result.last           = r_res.last;

endmodule
